[hdl/tss_pkg.sv]
package tss_pkg;

    localparam int MAX_NODES = 16;
    localparam int IDX_W     = 4;
    localparam int CNT_W     = 5;
    localparam int ROW_W     = 16;

    typedef struct packed {
        logic             op;
        logic [IDX_W-1:0] row_index;
        logic [ROW_W-1:0] row_bits;
    } item_t;

    typedef struct packed {
        logic [IDX_W-1:0] vertex;
        logic             vertex_valid;
        logic             last;
        logic             all_sorted;
    } result_t;

    // command to the in-degree lanes
    typedef struct packed {
        logic clear;
        logic add;
        logic sub;
    } deg_cmd_t;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_RUN  = 1'b1;

endpackage

[hdl/tss_degree.sv]
module tss_degree (
    input  logic                            clk,
    input  tss_pkg::deg_cmd_t               cmd,
    input  logic [tss_pkg::MAX_NODES-1:0]   row,
    output logic [tss_pkg::MAX_NODES-1:0]   zero_mask,
    output logic [tss_pkg::MAX_NODES-1:0]   hit_mask
);

    logic [tss_pkg::CNT_W-1:0] deg_reg [tss_pkg::MAX_NODES];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < tss_pkg::MAX_NODES; i++)
        begin
            if (cmd.clear)
            begin
                deg_reg[i] <= '0;
            end
            else if (cmd.add && row[i])
            begin
                deg_reg[i] <= deg_reg[i] + tss_pkg::CNT_W'(1);
            end
            else if (cmd.sub && row[i] && (deg_reg[i] != '0))
            begin
                deg_reg[i] <= deg_reg[i] - tss_pkg::CNT_W'(1);
            end
        end
    end

    // hit: lane that drops to zero on this decrement
    always_comb
    begin
        for (int i = 0; i < tss_pkg::MAX_NODES; i++)
        begin
            zero_mask[i] = (deg_reg[i] == '0);
            hit_mask[i]  = row[i] && (deg_reg[i] == tss_pkg::CNT_W'(1));
        end
    end

endmodule

[hdl/topological_sort_source_removal_top.sv]
// Kahn topological sort over up to 16 vertices. An op 0 beat loads one
// adjacency row. An op 1 beat runs the sort over node_count vertices
// (values above 16 act as 16): in-degrees are built one adjacency row per
// cycle, zero-degree vertices are then queued one per cycle, and each
// dequeued vertex is emitted and its successors updated (dequeue, then
// queue check), with each successor it frees queued one per cycle. Run time
// is set by the single adjacency read port and the one-entry-per-cycle
// queue write. Results leave in topological order; the final result has
// last set and all_sorted tells whether every vertex was emitted. A run
// that emits nothing gives one result with vertex_valid low. item_ready is
// low while a run is in progress.
module topological_sort_source_removal_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               item_valid,
    output logic               item_ready,
    input  tss_pkg::item_t     item,
    output logic               result_valid,
    input  logic               result_ready,
    output tss_pkg::result_t   result
);

    localparam int N = tss_pkg::MAX_NODES;
    localparam int IW = tss_pkg::IDX_W;
    localparam int CW = tss_pkg::CNT_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_COUNT  = 3'd1;
    localparam logic [2:0] ST_SEED   = 3'd2;
    localparam logic [2:0] ST_ENQ    = 3'd3;
    localparam logic [2:0] ST_DEQ    = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [2:0]              state_reg, state_next;
    logic [CW-1:0]           node_count_reg;
    logic [CW-1:0]           n_reg, n_next;
    logic [IW-1:0]           cnt_reg, cnt_next;
    logic [CW-1:0]           head_reg, head_next;
    logic [CW-1:0]           tail_reg, tail_next;
    logic [N-1:0]            pend_reg, pend_next;
    logic                    hold_valid_reg, hold_valid_next;
    logic [IW-1:0]           hold_vertex_reg, hold_vertex_next;
    logic                    result_valid_reg, result_valid_next;
    tss_pkg::result_t        result_reg, result_next;

    logic [tss_pkg::ROW_W-1:0] adj_reg [N];
    logic [IW-1:0]             queue_reg [N];

    logic [N-1:0]            use_mask;
    logic [IW-1:0]           adj_addr;
    logic [N-1:0]            row_sel;
    logic [N-1:0]            zero_mask;
    logic [N-1:0]            hit_mask;
    tss_pkg::deg_cmd_t       deg_cmd;
    logic [IW-1:0]           deq_vertex;
    logic [IW-1:0]           low_idx;
    logic                    can_push;
    logic                    cfg_write;
    logic                    item_fire;
    logic                    enq_write;
    logic [CW-1:0]           n_sat;

    assign pready    = 1'b1;
    assign prdata    = {{(32 - CW){1'b0}}, node_count_reg};
    assign cfg_write = psel && penable && pwrite && (paddr[2] == 1'b0);

    assign item_ready   = (state_reg == ST_IDLE);
    assign item_fire    = item_valid && item_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign can_push     = !result_valid_reg || result_ready;

    assign n_sat = (node_count_reg > CW'(N)) ? CW'(N) : node_count_reg;

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            use_mask[i] = (CW'(i) < n_reg);
        end
    end

    // lowest pending vertex goes into the queue first
    always_comb
    begin
        low_idx = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (pend_reg[i])
            begin
                low_idx = IW'(i);
            end
        end
    end

    assign deq_vertex = queue_reg[head_reg[IW-1:0]];
    assign adj_addr   = (state_reg == ST_COUNT) ? cnt_reg : deq_vertex;
    assign row_sel    = adj_reg[adj_addr] & use_mask;

    tss_degree u_degree (
        .clk       (clk),
        .cmd       (deg_cmd),
        .row       (row_sel),
        .zero_mask (zero_mask),
        .hit_mask  (hit_mask)
    );

    always_comb
    begin
        state_next        = state_reg;
        n_next            = n_reg;
        cnt_next          = cnt_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;
        pend_next         = pend_reg;
        hold_valid_next   = hold_valid_reg;
        hold_vertex_next  = hold_vertex_reg;
        result_valid_next = result_valid_reg && !result_ready;
        result_next       = result_reg;
        deg_cmd           = '0;
        enq_write         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_fire && (item.op == tss_pkg::OP_RUN))
                begin
                    n_next          = n_sat;
                    cnt_next        = '0;
                    head_next       = '0;
                    tail_next       = '0;
                    hold_valid_next = 1'b0;
                    deg_cmd.clear   = 1'b1;
                    state_next      = (n_sat == '0) ? ST_FINISH : ST_COUNT;
                end
            end
            ST_COUNT:
            begin
                deg_cmd.add = 1'b1;
                cnt_next    = cnt_reg + IW'(1);
                if ({1'b0, cnt_reg} == (n_reg - CW'(1)))
                begin
                    state_next = ST_SEED;
                end
            end
            ST_SEED:
            begin
                pend_next  = zero_mask & use_mask;
                state_next = ST_ENQ;
            end
            ST_ENQ:
            begin
                if (pend_reg != '0)
                begin
                    enq_write = 1'b1;
                    tail_next = tail_reg + CW'(1);
                    pend_next = pend_reg & (pend_reg - N'(1));
                end
                else if (head_reg < tail_reg)
                begin
                    state_next = ST_DEQ;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_DEQ:
            begin
                // one result is held back so the final one can carry last
                if (!hold_valid_reg || can_push)
                begin
                    if (hold_valid_reg)
                    begin
                        result_valid_next        = 1'b1;
                        result_next.vertex       = hold_vertex_reg;
                        result_next.vertex_valid = 1'b1;
                        result_next.last         = 1'b0;
                        result_next.all_sorted   = 1'b0;
                    end
                    deg_cmd.sub      = 1'b1;
                    pend_next        = hit_mask;
                    hold_valid_next  = 1'b1;
                    hold_vertex_next = deq_vertex;
                    head_next        = head_reg + CW'(1);
                    state_next       = ST_ENQ;
                end
            end
            ST_FINISH:
            begin
                if (can_push)
                begin
                    result_valid_next = 1'b1;
                    result_next.last  = 1'b1;
                    if (hold_valid_reg)
                    begin
                        result_next.vertex       = hold_vertex_reg;
                        result_next.vertex_valid = 1'b1;
                        result_next.all_sorted   = (head_reg == n_reg);
                    end
                    else
                    begin
                        result_next.vertex       = '0;
                        result_next.vertex_valid = 1'b0;
                        result_next.all_sorted   = (n_reg == '0);
                    end
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            node_count_reg   <= CW'(N);
            n_reg            <= '0;
            cnt_reg          <= '0;
            head_reg         <= '0;
            tail_reg         <= '0;
            pend_reg         <= '0;
            hold_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            for (int i = 0; i < N; i++)
            begin
                adj_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            n_reg            <= n_next;
            cnt_reg          <= cnt_next;
            head_reg         <= head_next;
            tail_reg         <= tail_next;
            pend_reg         <= pend_next;
            hold_valid_reg   <= hold_valid_next;
            result_valid_reg <= result_valid_next;
            if (cfg_write)
            begin
                node_count_reg <= pwdata[CW-1:0];
            end
            if (item_fire && (item.op == tss_pkg::OP_LOAD))
            begin
                adj_reg[item.row_index] <= item.row_bits;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hold_vertex_reg <= hold_vertex_next;
        result_reg      <= result_next;
        if (enq_write)
        begin
            queue_reg[tail_reg[IW-1:0]] <= low_idx;
        end
    end

endmodule

[tb/topological_sort_source_removal_top_tb.sv]
module topological_sort_source_removal_top_tb;
    import tss_pkg::*;

    localparam logic [2:0] NODE_COUNT_ADDR = 3'd0;
    localparam int DRAIN_CYCLES = 64;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int TOTAL_ITEMS  = 170;
    localparam int PHASE_ITEMS  = 20;
    localparam int GAP_PERCENT  = 23;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [2:0]  paddr        = '0;
    logic [31:0] pwdata       = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        item_valid   = 1'b0;
    logic        item_ready;
    item_t       item         = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    result_t     result;

    item_t            pend_items[$];
    result_t          due_vertices[$];
    logic [ROW_W-1:0] graph_rows [MAX_NODES];
    logic [4:0]       node_cfg   = 5'd16;

    int fails      = 0;
    int items_made = 0;
    int cyc        = 0;
    bit no_gaps    = 1'b0;
    bit want_hold  = 1'b0;
    bit hold_done  = 1'b0;
    int hold_cnt   = 0;

    topological_sort_source_removal_top DUT (.*);

    initial begin
        forever #4 clk = ~clk;
    end

    // Kahn source removal over the mirrored adjacency rows; queues the beats a run emits
    function automatic void kahn_predict(input item_t it);
        int               n;
        int               cnt;
        int               head;
        int               tail;
        int               u;
        logic [4:0]       indeg [MAX_NODES];
        logic [IDX_W-1:0] ready_order [MAX_NODES];
        result_t          emitted [MAX_NODES];
        if (it.op == OP_LOAD) begin
            graph_rows[it.row_index] = it.row_bits;
            return;
        end
        n = (node_cfg > MAX_NODES) ? MAX_NODES : int'(node_cfg);
        for (int v = 0; v < n; v++) begin
            indeg[v] = '0;
            for (int s = 0; s < n; s++)
                if (graph_rows[s][v])
                    indeg[v]++;
        end
        head = 0;
        tail = 0;
        cnt  = 0;
        for (int v = 0; v < n; v++)
            if (indeg[v] == 0)
            begin
                ready_order[tail] = IDX_W'(v);
                tail++;
            end
        while (head < tail)
        begin
            u = ready_order[head];
            head++;
            emitted[cnt] = '{vertex: IDX_W'(u), vertex_valid: 1'b1, last: 1'b0,
                             all_sorted: 1'b0};
            cnt++;
            for (int v = 0; v < n; v++)
                if (graph_rows[u][v] && indeg[v] != 0)
                begin
                    indeg[v]--;
                    if (indeg[v] == 0)
                    begin
                        ready_order[tail] = IDX_W'(v);
                        tail++;
                    end
                end
        end
        if (cnt == 0)
            due_vertices.push_back('{vertex: '0, vertex_valid: 1'b0, last: 1'b1,
                                     all_sorted: (n == 0)});
        else
        begin
            emitted[cnt-1].last       = 1'b1;
            emitted[cnt-1].all_sorted = (cnt == n);
            for (int k = 0; k < cnt; k++)
                due_vertices.push_back(emitted[k]);
        end
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
            item_valid <= 1'b0;
        else
        begin
            if (item_valid && item_ready)
                kahn_predict(item);
            if (!item_valid || item_ready)
            begin
                if (pend_items.size() != 0 && (no_gaps || $urandom_range(99) >= GAP_PERCENT))
                begin
                    item       <= pend_items.pop_front();
                    item_valid <= 1'b1;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin : monitor
        result_t want;
        if (result_valid && result_ready)
        begin
            if (due_vertices.size() == 0)
            begin
                $error("result beat with nothing pending: %p", result);
                fails++;
            end
            else
            begin
                want = due_vertices.pop_front();
                if (result.vertex !== want.vertex)
                begin
                    $error("vertex: expected %0d, got %0d", want.vertex, result.vertex);
                    fails++;
                end
                if (result.vertex_valid !== want.vertex_valid)
                begin
                    $error("vertex_valid: expected %0d, got %0d",
                           want.vertex_valid, result.vertex_valid);
                    fails++;
                end
                if (result.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, result.last);
                    fails++;
                end
                if (result.all_sorted !== want.all_sorted)
                begin
                    $error("all_sorted: expected %0d, got %0d",
                           want.all_sorted, result.all_sorted);
                    fails++;
                end
            end
        end
        // one long hold once results start showing up, to back the block up
        if (want_hold && !hold_done && (hold_cnt > 0 || result_valid))
        begin
            hold_cnt     <= hold_cnt + 1;
            result_ready <= 1'b0;
            if (hold_cnt == HOLD_CYCLES - 1)
                hold_done <= 1'b1;
        end
        else
            result_ready <= no_gaps || ($urandom_range(99) >= GAP_PERCENT);
    end

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc == CYCLE_LIMIT)
        begin
            $display("topological_sort_source_removal_top: mismatch");
            $finish;
        end
    end

    task automatic push_load(input logic [IDX_W-1:0] idx, input logic [ROW_W-1:0] bits);
        item_t it;
        it.op        = OP_LOAD;
        it.row_index = idx;
        it.row_bits  = bits;
        pend_items.push_back(it);
        items_made++;
    endtask

    task automatic push_run();
        item_t it;
        it.op        = OP_RUN;
        it.row_index = IDX_W'($urandom);
        it.row_bits  = ROW_W'($urandom);
        pend_items.push_back(it);
        items_made++;
    endtask

    // wait for all beats to drain, then give a trailing row load time to land
    task automatic settle();
        while (pend_items.size() != 0 || item_valid || due_vertices.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_node_count(input logic [4:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= NODE_COUNT_ADDR;
        pwdata  <= {27'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        node_cfg = value;
        @(negedge clk);
    endtask

    // mostly full DAG reloads under a random vertex ranking, some scattered noisy rows
    task automatic add_graph_burst();
        int               n;
        int               j;
        int               t;
        int               rank [MAX_NODES];
        logic [ROW_W-1:0] bits;
        n = (node_cfg > MAX_NODES) ? MAX_NODES : int'(node_cfg);
        for (int i = 0; i < MAX_NODES; i++)
            rank[i] = i;
        for (int i = MAX_NODES - 1; i > 0; i--)
        begin
            j       = $urandom_range(i);
            t       = rank[i];
            rank[i] = rank[j];
            rank[j] = t;
        end
        if ($urandom_range(99) < 70)
        begin
            for (int u = 0; u < n; u++)
            begin
                bits = '0;
                for (int v = 0; v < MAX_NODES; v++)
                    if (rank[v] > rank[u] && $urandom_range(2) == 0)
                        bits[v] = 1'b1;
                // occasional stray edge, may close a cycle or a self loop
                if ($urandom_range(9) == 0)
                    bits[$urandom_range(MAX_NODES - 1)] = 1'b1;
                push_load(IDX_W'(u), bits);
            end
        end
        else
        begin
            repeat ($urandom_range(3, 1))
                push_load(IDX_W'($urandom_range(MAX_NODES - 1)), ROW_W'($urandom));
        end
        push_run();
    endtask

    initial begin
        int         phase;
        int         phase_start;
        logic [4:0] cfg_list [8];
        cfg_list = '{5'd5, 5'd16, 5'd2, 5'd31, 5'd9, 5'd1, 5'd12, 5'd3};
        for (int i = 0; i < MAX_NODES; i++)
            graph_rows[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty graph: every vertex in index order
        push_run();
        // 15 feeds everyone and itself: nothing comes out
        push_load(4'd15, 16'hFFFF);
        push_run();
        push_load(4'd15, 16'h7FFF);
        push_run();
        // self loop on 0
        push_load(4'd0, 16'h0001);
        push_run();
        // a loop between 3 and 15 (3 -> 15 -> 3) blocks everything
        push_load(4'd3, 16'h8000);
        push_run();
        settle();
        write_node_count(5'd0);
        push_run();
        settle();
        write_node_count(5'd1);
        push_run();
        // only out-of-range edges
        push_load(4'd0, 16'hFFFE);
        push_run();
        settle();
        write_node_count(5'd31);
        push_load(4'd15, 16'h0000);
        push_load(4'd3, 16'h0000);
        push_run();
        settle();
        write_node_count(5'd17);
        push_load(4'd7, 16'h0480);
        push_run();

        phase = 0;
        while (items_made < TOTAL_ITEMS)
        begin
            settle();
            write_node_count(cfg_list[phase % 8]);
            no_gaps     = (phase == 3);
            want_hold   = (phase == 1);
            phase_start = items_made;
            while (items_made - phase_start < PHASE_ITEMS)
                add_graph_burst();
            phase++;
        end
        settle();

        if (fails == 0 && due_vertices.size() == 0)
            $display("topological_sort_source_removal_top: match");
        else
            $display("topological_sort_source_removal_top: mismatch");
        $finish;
    end

endmodule

[topological_sort_source_removal_top.f]
hdl/tss_pkg.sv
hdl/tss_degree.sv
hdl/topological_sort_source_removal_top.sv
tb/topological_sort_source_removal_top_tb.sv
